// ----- rtl/psrl_pkg.sv -----
// Shared types and constants of the per-source access rate limiter.
// No dependencies; the core and the testbench import this package, psrl_ram does not.
package psrl_pkg;

    localparam int ADDR_W   = 32;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int REPORT_W = 7;
    localparam int CFG_W    = 32;

    // Request codes.
    localparam logic [1:0] REQ_CHECK  = 2'd0;
    localparam logic [1:0] REQ_SECOND = 2'd1;
    localparam logic [1:0] REQ_SWEEP  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_LOCK_TIME = 2'd1;
    localparam logic [1:0] CFG_IDLE_TIME = 2'd2;

    localparam logic [REPORT_W-1:0] REPORT_MAX = '1;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] ip_address;
        logic [TIME_W-1:0] time_marker;
    } t_req;

    typedef struct packed {
        logic                allowed;
        logic                attack_detected;
        logic                insert_failed;
        logic [REPORT_W-1:0] unlocked_count;
        logic [REPORT_W-1:0] evicted_count;
    } t_rsp;

    // One slot of the source table as held in the RAM.
    typedef struct packed {
        logic               valid;
        logic               locked;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  last_time;
        logic [ADDR_W-1:0]  address;
    } t_entry;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

// ----- rtl/psrl_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module psrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/per_source_access_rate_limiter_core.sv -----
// Top level of the per-source access rate limiter: sequencer and slot evaluator.
// Depends on psrl_pkg and holds the source table in one psrl_ram instance.
//
//  channel   handshake              payload        direction
//  request   i_start / o_busy       i_req (t_req)  in
//  result    o_done (strobe)        o_rsp (t_rsp)  out
//  config    i_cfg_we               i_cfg_addr, i_cfg_wdata  in
//
// Each check, second or sweep beat scans the table slot by slot, one slot read per
// cycle from the RAM, with the compare and update of a slot in the cycle after its
// read. A second or sweep tick scans every slot; a check stops early on a hit. An
// unused request code answers the cycle after it is taken. After reset a clearing
// pass that writes every slot to zero holds o_busy high. The result is shown
// for one cycle with o_done; the receiver cannot stall it.
module per_source_access_rate_limiter_core
    import psrl_pkg::*;
#(
    parameter int TABLE_ENTRIES       = 64,
    parameter int MAX_EVICT_PER_SWEEP = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  t_req             i_req,
    output logic             o_done,
    output t_rsp             o_rsp,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0]       ENTRIES_C = CW'(TABLE_ENTRIES);
    localparam logic [IW-1:0]       LAST_IDX  = IW'(TABLE_ENTRIES - 1);
    localparam logic [REPORT_W-1:0] EVICT_MAX = REPORT_W'(MAX_EVICT_PER_SWEEP);

    t_state r_state, n_state;

    logic [COUNT_W-1:0]  r_threshold;
    logic [TIME_W-1:0]   r_lock_time;
    logic [TIME_W-1:0]   r_idle_time;
    logic [TIME_W-1:0]   r_cur_time;

    logic [CW-1:0]       r_rd_cnt, n_rd_cnt;
    logic                r_pend, n_pend;
    logic [IW-1:0]       r_pend_idx;
    logic                r_free_found, n_free_found;
    logic [IW-1:0]       r_free_idx, n_free_idx;
    logic [REPORT_W-1:0] r_released, n_released;
    logic [REPORT_W-1:0] r_evicted, n_evicted;

    t_req                r_req;
    t_rsp                r_rsp, n_rsp;
    logic                r_done;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    t_entry              ram_wdata;
    logic [IW-1:0]       ram_raddr;
    logic [$bits(t_entry)-1:0] ram_rdata;
    t_entry              ent;

    logic                accept;
    logic                issue;
    logic                scan_done;
    logic                last_slot;
    logic [TIME_W-1:0]   delta;

    psrl_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ent       = t_entry'(ram_rdata);
    assign accept    = i_start && (r_state == ST_IDLE);
    assign issue     = (r_state == ST_SCAN) && (r_rd_cnt < ENTRIES_C);
    assign last_slot = (r_pend_idx == LAST_IDX);
    assign delta     = r_cur_time - ent.last_time;
    assign ram_raddr = r_rd_cnt[IW-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_rd_cnt[IW-1:0] == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start && (i_req.req_type inside {REQ_CHECK, REQ_SECOND, REQ_SWEEP})) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Table access, slot evaluation and result.
    always_comb begin
        ram_we       = 1'b0;
        ram_waddr    = r_pend_idx;
        ram_wdata    = ent;
        scan_done    = 1'b0;
        n_rsp        = '0;
        n_rd_cnt     = r_rd_cnt;
        n_pend       = 1'b0;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_released   = r_released;
        n_evicted    = r_evicted;

        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_rd_cnt[IW-1:0];
                ram_wdata = '0;
                n_rd_cnt  = r_rd_cnt + CW'(1);
            end
            ST_IDLE: begin
                n_rd_cnt     = '0;
                n_free_found = 1'b0;
                n_released   = '0;
                n_evicted    = '0;
            end
            ST_SCAN: begin
                n_pend   = issue;
                n_rd_cnt = r_rd_cnt + CW'(issue);
                if (r_pend) begin
                    case (r_req.req_type)
                        REQ_CHECK: begin
                            if (ent.valid && (ent.address == r_req.ip_address)) begin
                                scan_done = 1'b1;
                                if (!ent.locked) begin
                                    ram_we              = 1'b1;
                                    ram_wdata.last_time = r_cur_time;
                                    if (ent.count < r_threshold) begin
                                        ram_wdata.count = ent.count + COUNT_W'(1);
                                        n_rsp.allowed   = 1'b1;
                                    end else begin
                                        ram_wdata.locked      = 1'b1;
                                        n_rsp.attack_detected = 1'b1;
                                    end
                                end
                            end else begin
                                if (!ent.valid && !r_free_found) begin
                                    n_free_found = 1'b1;
                                    n_free_idx   = r_pend_idx;
                                end
                                if (last_slot) begin
                                    // No hit anywhere: store the source in the lowest free slot.
                                    scan_done     = 1'b1;
                                    n_rsp.allowed = 1'b1;
                                    if (n_free_found) begin
                                        ram_we              = 1'b1;
                                        ram_waddr           = n_free_idx;
                                        ram_wdata.valid     = 1'b1;
                                        ram_wdata.locked    = 1'b0;
                                        ram_wdata.count     = COUNT_W'(1);
                                        ram_wdata.last_time = r_cur_time;
                                        ram_wdata.address   = r_req.ip_address;
                                    end else begin
                                        n_rsp.insert_failed = 1'b1;
                                    end
                                end
                            end
                        end
                        REQ_SECOND: begin
                            if (ent.valid && !ent.locked) begin
                                ram_we          = 1'b1;
                                ram_wdata.count = '0;
                            end
                            scan_done = last_slot;
                        end
                        REQ_SWEEP: begin
                            if (ent.valid) begin
                                if (ent.locked) begin
                                    if (delta > r_lock_time) begin
                                        ram_we              = 1'b1;
                                        ram_wdata.locked    = 1'b0;
                                        ram_wdata.count     = '0;
                                        ram_wdata.last_time = r_cur_time;
                                        if (r_released != REPORT_MAX) begin
                                            n_released = r_released + REPORT_W'(1);
                                        end
                                    end
                                end else if ((delta > r_idle_time) && (r_evicted < EVICT_MAX)) begin
                                    ram_we          = 1'b1;
                                    ram_wdata.valid = 1'b0;
                                    n_evicted       = r_evicted + REPORT_W'(1);
                                end
                            end
                            scan_done            = last_slot;
                            n_rsp.unlocked_count = n_released;
                            n_rsp.evicted_count  = n_evicted;
                        end
                        default: scan_done = 1'b1;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_threshold  <= COUNT_W'(100);
            r_lock_time  <= TIME_W'(300);
            r_idle_time  <= TIME_W'(600);
            r_cur_time   <= '0;
            r_rd_cnt     <= '0;
            r_pend       <= 1'b0;
            r_free_found <= 1'b0;
            r_released   <= '0;
            r_evicted    <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rd_cnt     <= n_rd_cnt;
            r_pend       <= n_pend;
            r_free_found <= n_free_found;
            r_released   <= n_released;
            r_evicted    <= n_evicted;
            // An unused request code answers without a scan, with an all-zero result.
            r_done       <= scan_done || (accept && !(i_req.req_type inside
                            {REQ_CHECK, REQ_SECOND, REQ_SWEEP}));
            if (accept && (i_req.req_type == REQ_SECOND)) begin
                r_cur_time <= i_req.time_marker;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_THRESHOLD: r_threshold <= i_cfg_wdata[COUNT_W-1:0];
                    CFG_LOCK_TIME: r_lock_time <= i_cfg_wdata[TIME_W-1:0];
                    CFG_IDLE_TIME: r_idle_time <= i_cfg_wdata[TIME_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= r_rd_cnt[IW-1:0];
        r_free_idx <= n_free_idx;
        if (accept) begin
            r_req <= i_req;
            r_rsp <= '0;
        end else if (scan_done) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for per_source_access_rate_limiter_core.
// Depends on psrl_pkg and the core RTL: a directed table, then random traffic in three
// idle phases, each result checked against a fixed value or a cycle-free model of the table.
module tb_top
    import psrl_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_ENTRIES   = 64;
    localparam int MAX_EVICT       = 16;
    localparam int POOL_SIZE       = 24;
    localparam int BEATS_PER_PHASE = 270;
    localparam int STALL_LIMIT     = 4000;
    localparam int PRINT_LIMIT     = 100;

    // The package names no constant for the fourth request code.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam t_rsp RSP_NONE   = '0;
    localparam t_rsp RSP_ALLOW  = {1'b1, 1'b0, 1'b0, 7'd0, 7'd0};
    localparam t_rsp RSP_ATTACK = {1'b0, 1'b1, 1'b0, 7'd0, 7'd0};

    typedef enum logic {ROW_BEAT, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        t_req             beat;
        logic [1:0]       reg_index;
        logic [CFG_W-1:0] reg_data;
        logic             typed;
        t_rsp             want;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_start = 1'b0;
    logic             o_busy;
    t_req             i_req = '0;
    logic             o_done;
    t_rsp             o_rsp;
    logic             i_cfg_we = 1'b0;
    logic [1:0]       i_cfg_addr = '0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    // Model of the source table and of the registers.
    logic                tbl_valid  [TABLE_ENTRIES];
    logic [ADDR_W-1:0]   tbl_addr   [TABLE_ENTRIES];
    logic                tbl_locked [TABLE_ENTRIES];
    logic [COUNT_W-1:0]  tbl_count  [TABLE_ENTRIES];
    logic [TIME_W-1:0]   tbl_last   [TABLE_ENTRIES];
    logic [TIME_W-1:0]   now_time = '0;
    logic [COUNT_W-1:0]  threshold_reg = 16'd100;
    logic [TIME_W-1:0]   lock_time_reg = 32'd300;
    logic [TIME_W-1:0]   idle_time_reg = 32'd600;

    t_rsp              pending_verdicts [$];
    t_row              directed_rows [$];
    logic [ADDR_W-1:0] src_pool [POOL_SIZE];
    int                mismatch_count = 0;
    int                beats_sent = 0;
    int                idle_pct = 31;
    int                stall_cycles = 0;

    per_source_access_rate_limiter_core #(
        .TABLE_ENTRIES       (TABLE_ENTRIES),
        .MAX_EVICT_PER_SWEEP (MAX_EVICT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_rsp limiter_predict(input t_req beat);
        t_rsp              r;
        int                free_slot;
        bit                hit;
        int                released;
        int                evicted;
        logic [TIME_W-1:0] delta;
        r = '0;
        free_slot = TABLE_ENTRIES;
        hit = 1'b0;
        released = 0;
        evicted = 0;
        case (beat.req_type)
            REQ_CHECK: begin
                for (int i = 0; i < TABLE_ENTRIES && !hit; i++) begin
                    if (tbl_valid[i] && tbl_addr[i] == beat.ip_address) begin
                        hit = 1'b1;
                        if (!tbl_locked[i]) begin
                            tbl_last[i] = now_time;
                            if (tbl_count[i] < threshold_reg) begin
                                tbl_count[i] = tbl_count[i] + COUNT_W'(1);
                                r.allowed = 1'b1;
                            end else begin
                                tbl_locked[i] = 1'b1;
                                r.attack_detected = 1'b1;
                            end
                        end
                    end else if (!tbl_valid[i] && free_slot == TABLE_ENTRIES) begin
                        free_slot = i;
                    end
                end
                if (!hit) begin
                    r.allowed = 1'b1;
                    if (free_slot == TABLE_ENTRIES) begin
                        r.insert_failed = 1'b1;
                    end else begin
                        tbl_valid[free_slot]  = 1'b1;
                        tbl_addr[free_slot]   = beat.ip_address;
                        tbl_locked[free_slot] = 1'b0;
                        tbl_count[free_slot]  = 16'd1;
                        tbl_last[free_slot]   = now_time;
                    end
                end
            end
            REQ_SECOND: begin
                now_time = beat.time_marker;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (tbl_valid[i] && !tbl_locked[i]) tbl_count[i] = '0;
            end
            REQ_SWEEP: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (tbl_valid[i]) begin
                        delta = now_time - tbl_last[i];
                        if (tbl_locked[i]) begin
                            if (delta > lock_time_reg) begin
                                tbl_locked[i] = 1'b0;
                                tbl_count[i]  = '0;
                                tbl_last[i]   = now_time;
                                if (released < 127) released++;
                            end
                        end else if (delta > idle_time_reg && evicted < MAX_EVICT) begin
                            tbl_valid[i] = 1'b0;
                            evicted++;
                        end
                    end
                end
                r.unlocked_count = released[REPORT_W-1:0];
                r.evicted_count  = evicted[REPORT_W-1:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_req make_beat(input logic [1:0] code, input logic [ADDR_W-1:0] addr,
                                       input logic [TIME_W-1:0] tmark);
        t_req b;
        b.req_type    = code;
        b.ip_address  = addr;
        b.time_marker = tmark;
        return b;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Random sender gaps: mostly short, now and then long enough to span a whole scan.
    task automatic sender_pause();
        int n;
        n = 0;
        while ($urandom_range(99) < idle_pct) n++;
        if ($urandom_range(99) < idle_pct / 4) n += $urandom_range(1, TABLE_ENTRIES + 4);
        if (n > 0) begin
            i_start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic issue_beat(input t_req beat, input bit typed = 1'b0, input t_rsp want = '0);
        t_rsp predicted;
        i_start <= 1'b1;
        i_req   <= beat;
        do @(posedge i_clk); while (o_busy);
        predicted = limiter_predict(beat);
        pending_verdicts.push_back(typed ? want : predicted);
        beats_sent++;
        sender_pause();
    endtask

    task automatic drain_block();
        i_start <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // The block must be idle; the extra edge keeps we from toggling twice in one step.
    task automatic write_register(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_THRESHOLD: threshold_reg = data[COUNT_W-1:0];
            CFG_LOCK_TIME: lock_time_reg = data[TIME_W-1:0];
            CFG_IDLE_TIME: idle_time_reg = data[TIME_W-1:0];
            default: ;
        endcase
    endtask

    task automatic row_beat(input logic [1:0] code, input logic [ADDR_W-1:0] addr,
                            input logic [TIME_W-1:0] tmark, input bit typed, input t_rsp want);
        t_row r;
        r = '0;
        r.kind  = ROW_BEAT;
        r.beat  = make_beat(code, addr, tmark);
        r.typed = typed;
        r.want  = want;
        directed_rows.push_back(r);
    endtask

    task automatic row_write(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        t_row r;
        r = '0;
        r.kind      = ROW_WRITE;
        r.reg_index = idx;
        r.reg_data  = data;
        directed_rows.push_back(r);
    endtask

    // Fills the table with fresh sources and runs past its end.
    task automatic flood_table();
        repeat (TABLE_ENTRIES + 6) issue_beat(make_beat(REQ_CHECK, $urandom, $urandom));
    endtask

    task automatic random_sequence();
        int                pick;
        logic [ADDR_W-1:0] src;
        pick = $urandom_range(99);
        src  = src_pool[$urandom_range(POOL_SIZE - 1)];
        if (pick < 56) begin
            repeat ($urandom_range(1, 10)) issue_beat(make_beat(REQ_CHECK, src, $urandom));
        end else if (pick < 72) begin
            issue_beat(make_beat(REQ_SECOND, $urandom, now_time + $urandom_range(0, 8)));
        end else if (pick < 86) begin
            issue_beat(make_beat(REQ_SWEEP, $urandom, $urandom));
        end else if (pick < 88) begin
            flood_table();
        end else if (pick < 94) begin
            issue_beat(make_beat(REQ_CHECK, $urandom, $urandom));
        end else if (pick < 97) begin
            issue_beat(make_beat(REQ_SECOND, $urandom, $urandom));
        end else begin
            issue_beat(make_beat(REQ_UNUSED, $urandom, $urandom));
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result with nothing pending", 32'(o_rsp), '0);
            end else begin
                want = pending_verdicts.pop_front();
                if (o_rsp.allowed !== want.allowed)
                    report_mismatch("allowed", 32'(o_rsp.allowed), 32'(want.allowed));
                if (o_rsp.attack_detected !== want.attack_detected)
                    report_mismatch("attack_detected", 32'(o_rsp.attack_detected),
                                    32'(want.attack_detected));
                if (o_rsp.insert_failed !== want.insert_failed)
                    report_mismatch("insert_failed", 32'(o_rsp.insert_failed),
                                    32'(want.insert_failed));
                if (o_rsp.unlocked_count !== want.unlocked_count)
                    report_mismatch("unlocked_count", 32'(o_rsp.unlocked_count),
                                    32'(want.unlocked_count));
                if (o_rsp.evicted_count !== want.evicted_count)
                    report_mismatch("evicted_count", 32'(o_rsp.evicted_count),
                                    32'(want.evicted_count));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done || i_cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        foreach (tbl_valid[i]) begin
            tbl_valid[i]  = 1'b0;
            tbl_addr[i]   = '0;
            tbl_locked[i] = 1'b0;
            tbl_count[i]  = '0;
            tbl_last[i]   = '0;
        end

        // Directed part: reset values, field extremes, zero threshold, lock and idle limits.
        row_beat(REQ_SWEEP,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, RSP_NONE);
        row_beat(REQ_CHECK,  32'h0000_0000, 32'h0000_0000, 1'b1, RSP_ALLOW);
        row_beat(REQ_CHECK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, RSP_ALLOW);
        row_beat(REQ_CHECK,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, RSP_ALLOW);
        row_beat(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, RSP_NONE);
        row_beat(REQ_SECOND, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, RSP_NONE);
        row_write(CFG_THRESHOLD, 32'd0);
        row_beat(REQ_CHECK,  32'h0000_0000, 32'h0000_0000, 1'b1, RSP_ATTACK);
        row_beat(REQ_CHECK,  32'h0000_0000, 32'h0000_0000, 1'b1, RSP_NONE);
        row_beat(REQ_CHECK,  32'h1234_5678, 32'h0000_0000, 1'b1, RSP_ALLOW);
        row_beat(REQ_CHECK,  32'h1234_5678, 32'h0000_0000, 1'b1, RSP_ATTACK);
        row_write(CFG_LOCK_TIME, 32'd0);
        row_write(CFG_IDLE_TIME, 32'hFFFF_FFFF);
        row_beat(REQ_SECOND, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, RSP_NONE);
        row_beat(REQ_SWEEP,  32'h0000_0000, 32'h0000_0000, 1'b0, RSP_NONE);
        row_beat(REQ_CHECK,  32'h0000_0000, 32'h0000_0000, 1'b0, RSP_NONE);
        row_write(CFG_THRESHOLD, 32'h0000_FFFF);
        row_write(CFG_IDLE_TIME, 32'd0);
        row_beat(REQ_SECOND, 32'h0000_0000, 32'h0000_0005, 1'b1, RSP_NONE);
        row_beat(REQ_SWEEP,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, RSP_NONE);
        row_beat(REQ_CHECK,  32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, RSP_NONE);
        row_beat(REQ_CHECK,  32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b0, RSP_NONE);
        row_beat(REQ_SWEEP,  32'h0000_0000, 32'h0000_0000, 1'b0, RSP_NONE);
        row_write(CFG_LOCK_TIME, 32'hFFFF_FFFF);
        row_beat(REQ_SWEEP,  32'h0000_0000, 32'h0000_0000, 1'b0, RSP_NONE);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // The table clearing pass after reset holds busy high.
        while (o_busy) @(posedge i_clk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_WRITE) begin
                drain_block();
                write_register(directed_rows[k].reg_index, directed_rows[k].reg_data);
            end else begin
                issue_beat(directed_rows[k].beat, directed_rows[k].typed, directed_rows[k].want);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            drain_block();
            idle_pct = (phase == 0) ? 31 : (phase == 1) ? 84 : 0;
            case (phase)
                0: begin
                    write_register(CFG_THRESHOLD, $urandom_range(1, 6));
                    write_register(CFG_LOCK_TIME, $urandom_range(0, 20));
                    write_register(CFG_IDLE_TIME, $urandom_range(4, 30));
                end
                1: begin
                    write_register(CFG_THRESHOLD, 32'd1);
                    write_register(CFG_LOCK_TIME, 32'd0);
                    write_register(CFG_IDLE_TIME, 32'd0);
                end
                default: begin
                    write_register(CFG_THRESHOLD, $urandom_range(2, 12));
                    write_register(CFG_LOCK_TIME, $urandom_range(5, 40));
                    write_register(CFG_IDLE_TIME, $urandom_range(10, 60));
                end
            endcase
            foreach (src_pool[i]) src_pool[i] = $urandom;
            beats_sent = 0;
            // Start each phase from a full table so that the eviction bound is reached.
            flood_table();
            while (beats_sent < BEATS_PER_PHASE) random_sequence();
        end

        drain_block();
        repeat (TABLE_ENTRIES + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
